// ===== rtl/core/sha1s_pkg.sv =====
// sha1s_pkg: shared types and constants of the streaming SHA-1 hasher.
// No dependencies; sha1s_sched, sha1s_round, the hasher and the testbench import it.
`timescale 1ns / 1ps

package sha1s_pkg;

	typedef logic [31:0] word_t;
	typedef logic [0:4][31:0] chain_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} sha1s_state_t;

	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} sha1s_phase_t;

	// Control from the sequencer to the block buffer and the round unit.
	typedef struct packed {
		logic         shift_byte;
		logic [7:0]   byte_val;
		logic         init_round;
		logic         do_round;
		sha1s_phase_t phase;
	} sha1s_ctl_t;

	localparam chain_t INIT_CHAIN = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t K_CH   = 32'h5A827999;
	localparam word_t K_PAR1 = 32'h6ED9EBA1;
	localparam word_t K_MAJ  = 32'h8F1BBCDC;
	localparam word_t K_PAR2 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] PAR1_FIRST = 7'd20;
	localparam logic [6:0] MAJ_FIRST  = 7'd40;
	localparam logic [6:0] PAR2_FIRST = 7'd60;

endpackage

// ===== rtl/core/sha1s_msg_if.sv =====
// sha1s_msg_if: message byte channel of the SHA-1 hasher.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface sha1s_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

// ===== rtl/core/sha1s_digest_if.sv =====
// sha1s_digest_if: digest result channel of the SHA-1 hasher.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface sha1s_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_h0;
	logic [31:0] digest_h1;
	logic [31:0] digest_h2;
	logic [31:0] digest_h3;
	logic [31:0] digest_h4;

	modport source (output valid, output digest_h0, output digest_h1,
		output digest_h2, output digest_h3, output digest_h4, input ready);
	modport sink (input valid, input digest_h0, input digest_h1,
		input digest_h2, input digest_h3, input digest_h4, output ready);
endinterface

// ===== rtl/core/sha1s_sched.sv =====
// sha1s_sched: 64-byte block buffer that doubles as the message schedule window.
// Depends on sha1s_pkg.
`timescale 1ns / 1ps

module sha1s_sched
	import sha1s_pkg::*;
(
	input  logic       clk,
	input  sha1s_ctl_t ctl,
	output word_t      w_cur
);

	// Oldest byte sits at the top; the top word is W[t] during the rounds.
	logic [511:0] win_q;
	word_t        w_new;

	function automatic word_t win_word(input logic [511:0] v, input int idx);
		return v[511 - 32 * idx -: 32];
	endfunction

	always_comb begin
		word_t x;
		x = win_word(win_q, 13) ^ win_word(win_q, 8) ^ win_word(win_q, 2) ^
			win_word(win_q, 0);
		w_new = {x[30:0], x[31]};
	end

	assign w_cur = win_word(win_q, 0);

	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			win_q <= {win_q[503:0], ctl.byte_val};
		end else if (ctl.do_round) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

// ===== rtl/core/sha1s_round.sv =====
// sha1s_round: shared SHA-1 round datapath, one round per clock.
// Depends on sha1s_pkg.
`timescale 1ns / 1ps

module sha1s_round
	import sha1s_pkg::*;
(
	input  logic       clk,
	input  sha1s_ctl_t ctl,
	input  chain_t     chain,
	input  word_t      w_cur,
	output chain_t     vars
);

	chain_t vars_q;
	word_t  f;
	word_t  k;
	word_t  t;
	word_t  a, b, c, d, e;

	assign a = vars_q[0];
	assign b = vars_q[1];
	assign c = vars_q[2];
	assign d = vars_q[3];
	assign e = vars_q[4];

	always_comb begin
		case (ctl.phase)
			PH_CH: begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end
			PH_PAR1: begin
				f = b ^ c ^ d;
				k = K_PAR1;
			end
			PH_MAJ: begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end
			default: begin
				f = b ^ c ^ d;
				k = K_PAR2;
			end
		endcase
		t = {a[26:0], a[31:27]} + f + e + k + w_cur;
	end

	always_ff @(posedge clk) begin
		if (ctl.init_round) begin
			vars_q <= chain;
		end else if (ctl.do_round) begin
			vars_q <= {t, a, {b[1:0], b[31:2]}, c, d};
		end
	end

	assign vars = vars_q;

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// Streaming SHA-1 hasher: takes one message beat per cycle while ready, each beat carrying an
// optional byte and an end-of-message flag, and returns the 160-bit digest as five big-endian
// words on the digest channel, then starts over for the next message. The beat that completes
// a 64-byte block starts 80 rounds through the single shared round datapath at one round per
// clock, then ST_ADD folds the result into the chaining words. An end-of-message beat is
// followed by padding bytes written one per clock (9 to 72 of them, one or two more
// compressions) and the ST_OUT state that moves the digest into the output register;
// msg.ready stays low throughout. The digest beat holds in that register until taken while
// the next message streams in; a second finished digest waits, with msg.ready low, until the
// first one is taken. Depends on sha1s_pkg, the two channel interfaces, sha1s_sched and
// sha1s_round.
`timescale 1ns / 1ps

module sha1_stream_hasher
	import sha1s_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	sha1s_msg_if.sink      msg,
	sha1s_digest_if.source digest
);

	sha1s_state_t state_q, state_d;
	sha1s_ctl_t   ctl;
	chain_t       chain_q;
	chain_t       vars;
	chain_t       dig_q;
	word_t        w_cur;
	logic [63:0]  bits_q;
	logic [5:0]   pos_q;
	logic [6:0]   round_q;
	logic         fin_q;
	logic         last_q;
	logic         sent80_q;
	logic         len_ok_q;
	logic         dig_valid_q;
	logic [7:0]   pad_byte;
	logic [2:0]   len_sel;
	logic         msg_acc;
	logic         dig_acc;
	logic         dig_load;

	assign msg.ready = (state_q == ST_IDLE);
	assign msg_acc   = msg.valid && msg.ready;
	assign digest.valid = dig_valid_q;
	assign dig_acc      = digest.valid && digest.ready;
	// output register is free or being emptied this cycle
	assign dig_load     = (state_q == ST_OUT) && (!dig_valid_q || digest.ready);

	assign digest.digest_h0 = dig_q[0];
	assign digest.digest_h1 = dig_q[1];
	assign digest.digest_h2 = dig_q[2];
	assign digest.digest_h3 = dig_q[3];
	assign digest.digest_h4 = dig_q[4];

	// Length goes out big-endian at positions 56..63.
	assign len_sel = 3'd7 - pos_q[2:0];

	always_comb begin
		if (!sent80_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q && pos_q >= LEN_POS) begin
			pad_byte = 8'(bits_q >> {len_sel, 3'b000});
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		state_d        = state_q;
		ctl.shift_byte = 1'b0;
		ctl.byte_val   = 8'h00;
		ctl.init_round = 1'b0;
		ctl.do_round   = 1'b0;
		if (round_q < PAR1_FIRST) begin
			ctl.phase = PH_CH;
		end else if (round_q < MAJ_FIRST) begin
			ctl.phase = PH_PAR1;
		end else if (round_q < PAR2_FIRST) begin
			ctl.phase = PH_MAJ;
		end else begin
			ctl.phase = PH_PAR2;
		end
		case (state_q)
			ST_IDLE: begin
				if (msg.valid) begin
					if (msg.has_byte) begin
						ctl.shift_byte = 1'b1;
						ctl.byte_val   = msg.data_byte;
					end
					if (msg.has_byte && pos_q == BLOCK_LAST) begin
						ctl.init_round = 1'b1;
						state_d        = ST_COMP;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				ctl.do_round = 1'b1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (last_q) begin
					state_d = ST_OUT;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				ctl.shift_byte = 1'b1;
				ctl.byte_val   = pad_byte;
				if (pos_q == BLOCK_LAST) begin
					ctl.init_round = 1'b1;
					state_d        = ST_COMP;
				end
			end
			ST_OUT: begin
				if (dig_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= INIT_CHAIN;
			dig_q       <= '0;
			dig_valid_q <= 1'b0;
			bits_q      <= '0;
			pos_q       <= '0;
			round_q     <= '0;
			fin_q       <= 1'b0;
			last_q      <= 1'b0;
			sent80_q    <= 1'b0;
			len_ok_q    <= 1'b0;
		end else begin
			if (msg_acc) begin
				fin_q    <= msg.end_of_message;
				last_q   <= 1'b0;
				sent80_q <= 1'b0;
				len_ok_q <= 1'b0;
				if (msg.has_byte) begin
					bits_q <= bits_q + 64'd8;
				end
			end
			if (ctl.shift_byte) begin
				pos_q <= pos_q + 6'd1;
			end
			if (state_q == ST_PAD) begin
				if (!sent80_q) begin
					sent80_q <= 1'b1;
					if (pos_q < LEN_POS) begin
						len_ok_q <= 1'b1;
					end
				end
				// marker landed at byte 56 or later: length goes in the next block
				if (pos_q == BLOCK_LAST) begin
					len_ok_q <= 1'b1;
				end
				if (sent80_q && len_ok_q && pos_q == BLOCK_LAST) begin
					last_q <= 1'b1;
				end
			end
			if (ctl.init_round) begin
				round_q <= '0;
			end else if (ctl.do_round) begin
				round_q <= round_q + 7'd1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + vars[i];
				end
			end
			if (dig_load) begin
				dig_q       <= chain_q;
				dig_valid_q <= 1'b1;
				chain_q     <= INIT_CHAIN;
				bits_q      <= '0;
				fin_q       <= 1'b0;
				last_q      <= 1'b0;
			end else if (dig_acc) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	sha1s_sched u_sched (
		.clk   (clk),
		.ctl   (ctl),
		.w_cur (w_cur)
	);

	sha1s_round u_round (
		.clk   (clk),
		.ctl   (ctl),
		.chain (chain_q),
		.w_cur (w_cur),
		.vars  (vars)
	);

	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && !digest.ready) |=> (digest.valid && $stable(dig_q)))
		else $error("digest beat dropped or changed while held");

	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && round_q != ROUND_LAST) |=> round_q == $past(round_q) + 7'd1)
		else $error("round counter skipped");

	a_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init_round |=> (pos_q == 6'd0 && state_q == ST_COMP))
		else $error("compression started on partial block");

	a_fresh_message: assert property (@(posedge clk) disable iff (!arst_n)
		dig_load |=> (bits_q == 64'd0 && pos_q == 6'd0 && state_q == ST_IDLE))
		else $error("state not cleared after digest");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for sha1_stream_hasher. A built-in SHA-1 digest calculator checks
// every digest beat against the messages fed in, under random valid/ready idling.
// Depends on sha1s_pkg, sha1s_msg_if, sha1s_digest_if and the RTL of the hasher.
`timescale 1ns / 1ps

module tb_top;
	import sha1s_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_beat_t;

	localparam int MSG_ITEMS = 1800;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	sha1s_msg_if    msg_ch ();
	sha1s_digest_if dig_ch ();

	sha1_stream_hasher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// digest calculator state
	chain_t     chain_st;
	logic [63:0] bit_total;
	logic [7:0] blk_bytes [64];
	int         blk_fill;

	msg_beat_t pending [$];
	chain_t    digests_due [$];

	int total_beats = 0;
	int beats_done = 0;
	int items_done = 0;
	int digests_seen = 0;
	int mismatches = 0;
	int idle_phase;
	int send_gap_pct;
	int stall_pct;
	int hold_left;
	logic hold_done;
	logic beat_taken;
	msg_beat_t cur_beat;

	function automatic void compress_block();
		word_t w [80];
		word_t a, b, c, d, e, f, k, t;
		int r;
		for (r = 0; r < 16; r++)
			w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
		for (r = 16; r < 80; r++) begin
			t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
			w[r] = {t[30:0], t[31]};
		end
		a = chain_st[0];
		b = chain_st[1];
		c = chain_st[2];
		d = chain_st[3];
		e = chain_st[4];
		for (r = 0; r < 80; r++) begin
			if (r < PAR1_FIRST) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (r < MAJ_FIRST) begin
				f = b ^ c ^ d;
				k = K_PAR1;
			end else if (r < PAR2_FIRST) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR2;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_st[0] = chain_st[0] + a;
		chain_st[1] = chain_st[1] + b;
		chain_st[2] = chain_st[2] + c;
		chain_st[3] = chain_st[3] + d;
		chain_st[4] = chain_st[4] + e;
	endfunction

	function automatic void put_byte(logic [7:0] v);
		blk_bytes[blk_fill] = v;
		blk_fill++;
		if (blk_fill == 64) begin
			compress_block();
			blk_fill = 0;
		end
	endfunction

	// Applies one accepted beat; queues the digest when the beat closes a message.
	function automatic void hash_beat(msg_beat_t bt);
		logic [63:0] len;
		int i;
		if (bt.has_byte) begin
			blk_fill = int'(bit_total[8:3]);
			bit_total = bit_total + 64'd8;
			put_byte(bt.data_byte);
		end
		if (bt.end_of_message) begin
			len = bit_total;
			blk_fill = int'(bit_total[8:3]);
			put_byte(PAD_MARK);
			while (blk_fill != int'(LEN_POS))
				put_byte(8'h00);
			for (i = 7; i >= 0; i--)
				put_byte(len[8*i +: 8]);
			digests_due.push_back(chain_st);
			chain_st = INIT_CHAIN;
			bit_total = '0;
		end
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("MISMATCH %s: got %08h want %08h", what, got, want);
		mismatches++;
	endtask

	function automatic void push_beat(logic [7:0] data, logic has, logic eom);
		msg_beat_t bt;
		bt.data_byte = data;
		bt.has_byte = has;
		bt.end_of_message = eom;
		pending.push_back(bt);
	endfunction

	// Message of len random bytes, with stray empty beats mixed in. The end flag rides on the
	// last byte or comes as its own beat. Returns the number of beats that carry something.
	function automatic int add_message(int len, logic end_on_last);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 6)
				push_beat(8'($urandom), 1'b0, 1'b0);
			push_beat(8'($urandom), 1'b1, end_on_last && (i == len - 1));
		end
		if (len == 0 || !end_on_last) begin
			push_beat(8'($urandom), 1'b0, 1'b1);
			return len + 1;
		end
		return len;
	endfunction

	always_comb begin
		idle_phase = (total_beats == 0) ? 0 : (beats_done * 5) / total_beats;
		send_gap_pct = (idle_phase == 1) ? 73 : (idle_phase == 3) ? 11 : 0;
		stall_pct = (idle_phase == 2) ? 73 : (idle_phase == 3) ? 11 : 0;
	end

	// message driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
			msg_ch.data_byte <= '0;
			msg_ch.has_byte <= 1'b0;
			msg_ch.end_of_message <= 1'b0;
		end else begin
			beat_taken = msg_ch.valid && msg_ch.ready;
			if (beat_taken) begin
				hash_beat(cur_beat);
				beats_done++;
				if (cur_beat.has_byte || cur_beat.end_of_message)
					items_done++;
			end
			if (!msg_ch.valid || beat_taken) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					cur_beat = pending.pop_front();
					msg_ch.valid <= 1'b1;
					msg_ch.data_byte <= cur_beat.data_byte;
					msg_ch.has_byte <= cur_beat.has_byte;
					msg_ch.end_of_message <= cur_beat.end_of_message;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// digest receiver; one long hold-off when the receiver-stall phase starts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (idle_phase == 2 && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			dig_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dig_ch.ready <= 1'b0;
		end else begin
			dig_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// digest monitor
	always @(posedge clk) begin
		chain_t got, want;
		int i;
		if (arst_n && dig_ch.valid && dig_ch.ready) begin
			got = {dig_ch.digest_h0, dig_ch.digest_h1, dig_ch.digest_h2,
				dig_ch.digest_h3, dig_ch.digest_h4};
			if (digests_due.size() == 0) begin
				report_mismatch("digest beat with no message closed", got[0], '0);
			end else begin
				want = digests_due.pop_front();
				for (i = 0; i < 5; i++)
					if (got[i] !== want[i])
						report_mismatch($sformatf("digest_h%0d", i), got[i], want[i]);
			end
			digests_seen++;
		end
	end

	initial begin
		int counted;
		int len;
		int pad_edge_lens [13];
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.has_byte = 1'b0;
		msg_ch.end_of_message = 1'b0;
		dig_ch.ready = 1'b0;
		chain_st = INIT_CHAIN;
		bit_total = '0;
		blk_fill = 0;
		pad_edge_lens = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128, 129};

		// directed: empty message, idle beat, end on a byte, extreme bytes, end without a byte
		push_beat(8'h00, 1'b0, 1'b1);
		push_beat(8'hFF, 1'b0, 1'b0);
		push_beat(8'h61, 1'b1, 1'b0);
		push_beat(8'h62, 1'b1, 1'b0);
		push_beat(8'h63, 1'b1, 1'b1);
		push_beat(8'h00, 1'b1, 1'b1);
		push_beat(8'hFF, 1'b1, 1'b1);
		push_beat(8'h5A, 1'b1, 1'b0);
		push_beat(8'hA5, 1'b1, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'hC3, 1'b0, 1'b1);
		push_beat(8'hFF, 1'b0, 1'b1);
		counted = 10;

		// random messages; lengths lean short, with padding boundary lengths mixed in
		while (counted < MSG_ITEMS) begin
			case ($urandom_range(9))
				0, 1: len = pad_edge_lens[$urandom_range(12)];
				2: len = $urandom_range(200, 25);
				default: len = $urandom_range(24, 1);
			endcase
			counted += add_message(len, 1'($urandom_range(1)));
		end
		total_beats = pending.size();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || msg_ch.valid)
			@(posedge clk);
		while (digests_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d beats (%0d with a byte or end flag) across all idle/stall phases,",
			beats_done, items_done);
		$display("checked %0d digests, %0d mismatches", digests_seen, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout: %0d digests still outstanding", digests_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule
